[rtl/core/hrt_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP request tokenizer package
// Shared word types, token codes and keyword tables of the tokenizer.
// ----------------------------------------------------------------------------
package hrt_pkg;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_input;
   } req_word_type;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] word_byte;
      logic [1:0] keyword_code;
      logic       last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } lex_out_type;

   localparam logic [2:0] TK_END   = 3'd0;
   localparam logic [2:0] TK_COLON = 3'd1;
   localparam logic [2:0] TK_QMARK = 3'd2;
   localparam logic [2:0] TK_BLANK = 3'd3;
   localparam logic [2:0] TK_CRLF  = 3'd4;
   localparam logic [2:0] TK_WCHAR = 3'd5;
   localparam logic [2:0] TK_WEND  = 3'd6;

   localparam logic [1:0] KW_NONE = 2'd0;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_VT_LO = 8'h09;
   localparam logic [7:0] CH_VT_HI = 8'h0D;

   localparam int         KW_COUNT  = 3;
   localparam logic [2:0] MATCH_ALL = 3'b111;
   localparam logic [2:0] LEN_SAT   = 3'd5;

   localparam int QUEUE_DEPTH = 4;

   // Keyword lengths: GET, POST, HEAD.
   function automatic logic [2:0] kw_len(input logic [1:0] idx);
      logic [2:0] len;
      unique case (idx)
         2'd0:    len = 3'd3;
         2'd1:    len = 3'd4;
         2'd2:    len = 3'd4;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // Keyword text, one character per position.
   function automatic logic [7:0] kw_char(input logic [1:0] idx, input logic [1:0] pos);
      logic [7:0] ch;
      unique case ({idx, pos})
         4'b00_00: ch = 8'h47; // G
         4'b00_01: ch = 8'h45; // E
         4'b00_10: ch = 8'h54; // T
         4'b01_00: ch = 8'h50; // P
         4'b01_01: ch = 8'h4F; // O
         4'b01_10: ch = 8'h53; // S
         4'b01_11: ch = 8'h54; // T
         4'b10_00: ch = 8'h48; // H
         4'b10_01: ch = 8'h45; // E
         4'b10_10: ch = 8'h41; // A
         4'b10_11: ch = 8'h44; // D
         default:  ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

[rtl/core/hrt_lexer.sv]
// ----------------------------------------------------------------------------
// Tokenizer lexer
// Classifies one byte, tracks the open word and the keyword match, and
// produces up to two result words for the item.
// ----------------------------------------------------------------------------
module hrt_lexer
   import hrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_word_type item,
   output lex_out_type  lex_out
);

   logic       in_word_ff, in_word_in;
   logic       pending_cr_ff, pending_cr_in;
   logic [2:0] word_length_ff, word_length_in;
   logic [2:0] keyword_match_ff, keyword_match_in;

   logic       is_space;
   logic       is_word_byte;
   logic [1:0] kw_code;
   logic [2:0] start_len;
   logic [2:0] start_match;
   logic [2:0] byte_match;
   logic [2:0] delim_kind;
   rsp_word_type wend_word;

   always_comb begin
      is_space = (item.char_byte == CH_SPACE) ||
                 ((item.char_byte >= CH_VT_LO) && (item.char_byte <= CH_VT_HI));
      is_word_byte = (item.char_byte != CH_COLON) && !is_space &&
                     (in_word_ff || (item.char_byte != CH_QMARK));

      kw_code = KW_NONE;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         if (keyword_match_ff[i] && (word_length_ff == kw_len(2'(i)))) begin
            kw_code = 2'(i + 1);
         end
      end

      start_len   = in_word_ff ? word_length_ff : 3'd0;
      start_match = in_word_ff ? keyword_match_ff : MATCH_ALL;
      byte_match  = start_match;
      for (int i = 0; i < KW_COUNT; i++) begin
         if ((start_len >= kw_len(2'(i))) ||
             (kw_char(2'(i), start_len[1:0]) != item.char_byte)) begin
            byte_match[i] = 1'b0;
         end
      end

      if (item.char_byte == CH_COLON) begin
         delim_kind = TK_COLON;
      end else if (item.char_byte == CH_QMARK) begin
         delim_kind = TK_QMARK;
      end else if ((item.char_byte == CH_SPACE) || (item.char_byte == CH_TAB)) begin
         delim_kind = TK_BLANK;
      end else begin
         delim_kind = TK_CRLF;
      end

      wend_word = '{token_kind: TK_WEND, word_byte: 8'd0,
                    keyword_code: kw_code, last_of_run: 1'b0};

      lex_out.count  = 2'd1;
      lex_out.first  = '{token_kind: TK_END, word_byte: 8'd0,
                         keyword_code: KW_NONE, last_of_run: 1'b1};
      lex_out.second = lex_out.first;

      in_word_in       = 1'b0;
      pending_cr_in    = 1'b0;
      word_length_in   = 3'd0;
      keyword_match_in = MATCH_ALL;

      if (item.end_of_input) begin
         if (in_word_ff) begin
            lex_out.count = 2'd2;
            lex_out.first = wend_word;
         end
      end else if (pending_cr_ff && (item.char_byte == CH_LF)) begin
         lex_out.count = 2'd0;
         in_word_in       = in_word_ff;
         word_length_in   = word_length_ff;
         keyword_match_in = keyword_match_ff;
      end else if (is_word_byte) begin
         lex_out.first = '{token_kind: TK_WCHAR, word_byte: item.char_byte,
                           keyword_code: KW_NONE, last_of_run: 1'b1};
         in_word_in       = 1'b1;
         word_length_in   = (start_len < LEN_SAT) ? start_len + 3'd1 : start_len;
         keyword_match_in = byte_match;
      end else begin
         pending_cr_in = (item.char_byte == CH_CR);
         if (in_word_ff) begin
            lex_out.count = 2'd2;
            lex_out.first = wend_word;
            lex_out.second.token_kind = delim_kind;
         end else begin
            lex_out.first.token_kind = delim_kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff       <= 1'b0;
         pending_cr_ff    <= 1'b0;
         word_length_ff   <= 3'd0;
         keyword_match_ff <= MATCH_ALL;
      end else if (advance) begin
         in_word_ff       <= in_word_in;
         pending_cr_ff    <= pending_cr_in;
         word_length_ff   <= word_length_in;
         keyword_match_ff <= keyword_match_in;
      end
   end

endmodule

[rtl/core/hrt_out_queue.sv]
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Small queue: up to two result words in per cycle, one out unless stalled.
// ----------------------------------------------------------------------------
module hrt_out_queue
   import hrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  lex_out_type  push_data,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_word_type mem_ff [QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       push_n;
   logic             pop;

   always_comb begin
      push_n    = push ? push_data.count : 2'd0;
      rsp_valid = (count_ff != '0);
      rsp_word  = mem_ff[rd_ptr_ff];
      pop       = rsp_valid && !rsp_stall;
      room      = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data.first;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push_data.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/http_request_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// HTTP request tokenizer
// Turns a byte stream into token words with keyword detection.
// ----------------------------------------------------------------------------
// One input word (a byte or an end mark) is accepted every cycle while the
// result queue has room. It is held in an input register, classified against
// the tokenizer state combinationally, and its zero, one or two result words
// are written into a four-entry result queue. The queue hands out one
// result word per cycle while rsp_stall is low, so the sustained rate is one
// byte per cycle while each byte gives one result; a word-ending byte gives a
// word end and its delimiter. Results pass the input register and the queue.
module http_request_tokenizer_top
   import hrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         item_valid_ff, item_valid_in;
   req_word_type item_ff;
   logic         room;
   logic         advance;
   logic         accept;
   lex_out_type  lex_out;

   always_comb begin
      advance       = item_valid_ff && room;
      req_stall     = item_valid_ff && !room;
      accept        = req_valid && !req_stall;
      item_valid_in = accept ? 1'b1 : (advance ? 1'b0 : item_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_word;
      end
   end

   hrt_lexer u_lexer (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .lex_out (lex_out)
   );

   hrt_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (lex_out),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

[sim/http_request_tokenizer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request tokenizer testbench
// Feeds the tokenizer a short table of hand-picked bytes, then many random
// request lines, header lines and noise. Every token word is checked against
// the table's expected tokens or an in-bench model of the lexer, under three
// mixes of sender and receiver idling.
// ----------------------------------------------------------------------------
module http_request_tokenizer_top_tb;
   import hrt_pkg::*;

   localparam logic [1:0] KW_GET  = 2'd1;
   localparam logic [1:0] KW_POST = 2'd2;
   localparam logic [1:0] KW_HEAD = 2'd3;
   localparam logic [7:0] CH_VT   = 8'h0B;
   localparam logic [7:0] CH_FF   = 8'h0C;
   localparam int PHASE_WORDS = 550;
   localparam rsp_word_type NO_TOKEN = '0;

   typedef struct packed {
      req_word_type stim;
      logic         typed;
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatch_count = 0;

   rsp_word_type expected_tokens [$];
   rsp_word_type next_token;
   stim_row_type stim_rows [$];

   string      keyword_text [3] = '{"GET", "POST", "HEAD"};
   logic [7:0] delim_bytes [8] = '{CH_COLON, CH_QMARK, CH_SPACE, CH_TAB, CH_CR, CH_LF,
                                   CH_VT, CH_FF};

   logic       word_open = 1'b0;
   logic       cr_pending = 1'b0;
   logic [2:0] word_len = 3'd0;
   logic [2:0] kw_possible = MATCH_ALL;

   http_request_tokenizer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic rsp_word_type tok(logic [2:0] kind, logic [7:0] b, logic [1:0] kw,
                                        logic last);
      rsp_word_type t;
      t.token_kind   = kind;
      t.word_byte    = b;
      t.keyword_code = kw;
      t.last_of_run  = last;
      return t;
   endfunction

   function automatic stim_row_type row(logic [7:0] b, logic eoi, logic typed,
                                        logic [1:0] count, rsp_word_type first,
                                        rsp_word_type second);
      stim_row_type r;
      r.stim.char_byte    = b;
      r.stim.end_of_input = eoi;
      r.typed  = typed;
      r.count  = count;
      r.first  = first;
      r.second = second;
      return r;
   endfunction

   function automatic stim_row_type byte_row(logic [7:0] b);
      return row(b, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN);
   endfunction

   function automatic logic [1:0] keyword_of_word();
      if (kw_possible[0] && word_len == keyword_text[0].len()) return KW_GET;
      if (kw_possible[1] && word_len == keyword_text[1].len()) return KW_POST;
      if (kw_possible[2] && word_len == keyword_text[2].len()) return KW_HEAD;
      return KW_NONE;
   endfunction

   task automatic close_word();
      word_open   = 1'b0;
      word_len    = 3'd0;
      kw_possible = MATCH_ALL;
   endtask

   // Tokens caused by one accepted word; the keyword is tracked without text.
   task automatic tokenize_byte(input req_word_type w, ref rsp_word_type toks[$]);
      logic [7:0] b;
      logic [2:0] kind;
      b = w.char_byte;
      toks = {};
      if (w.end_of_input) begin
         if (word_open) begin
            toks.push_back(tok(TK_WEND, 8'h00, keyword_of_word(), 1'b0));
            close_word();
         end
         cr_pending = 1'b0;
         toks.push_back(tok(TK_END, 8'h00, KW_NONE, 1'b1));
      end else if (cr_pending && b == CH_LF) begin
         cr_pending = 1'b0;
      end else if (b != CH_COLON && !(b == CH_SPACE || (b >= CH_VT_LO && b <= CH_VT_HI))
                   && (word_open || b != CH_QMARK)) begin
         cr_pending = 1'b0;
         word_open  = 1'b1;
         for (int i = 0; i < 3; i++) begin
            if (word_len >= keyword_text[i].len() || keyword_text[i][word_len] != b)
               kw_possible[i] = 1'b0;
         end
         if (word_len < LEN_SAT) word_len++;
         toks.push_back(tok(TK_WCHAR, b, KW_NONE, 1'b1));
      end else begin
         if (word_open) begin
            toks.push_back(tok(TK_WEND, 8'h00, keyword_of_word(), 1'b0));
            close_word();
         end
         if (b == CH_COLON) kind = TK_COLON;
         else if (b == CH_QMARK) kind = TK_QMARK;
         else if (b == CH_SPACE || b == CH_TAB) kind = TK_BLANK;
         else kind = TK_CRLF;
         cr_pending = (b == CH_CR);
         toks.push_back(tok(kind, 8'h00, KW_NONE, 1'b1));
      end
   endtask

   task automatic add_byte(input logic [7:0] b);
      stim_rows.push_back(byte_row(b));
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_end();
      stim_rows.push_back(row(8'($urandom_range(255)), 1'b1, 1'b0, 2'd0, NO_TOKEN,
                              NO_TOKEN));
   endtask

   task automatic add_text_chars(input int n);
      repeat (n) add_byte(8'($urandom_range(8'h21, 8'h7E)));
   endtask

   task automatic add_line_end();
      case ($urandom_range(7))
         0:       add_byte(CH_LF);
         1:       add_byte(CH_CR);
         2:       begin
            add_byte(CH_CR);
            add_byte(CH_CR);
            add_byte(CH_LF);
         end
         default: begin
            add_byte(CH_CR);
            add_byte(CH_LF);
         end
      endcase
   endtask

   // A request line with zero to two headers; the method is sometimes mangled.
   task automatic add_request();
      string method;
      method = keyword_text[$urandom_range(2)];
      case ($urandom_range(11))
         0:       method = method.tolower();
         1:       method = method.substr(0, method.len() - 2);
         2:       method = {method, "S"};
         3:       method = {"X", method};
         default: ;
      endcase
      add_text(method);
      add_byte($urandom_range(3) == 0 ? CH_TAB : CH_SPACE);
      add_byte("/");
      add_text_chars($urandom_range(0, 7));
      if ($urandom_range(3) == 0) begin
         add_byte(CH_QMARK);
         add_text_chars($urandom_range(0, 5));
      end
      add_byte(CH_SPACE);
      add_text("HTTP/1.1");
      add_line_end();
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(2) == 0) add_text(keyword_text[$urandom_range(2)]);
         else add_text("Host");
         add_byte(CH_COLON);
         add_byte(CH_SPACE);
         add_text_chars($urandom_range(1, 6));
         add_line_end();
      end
      add_line_end();
      if ($urandom_range(3) == 0) add_end();
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(9))
            0, 1, 2, 3: add_byte(8'($urandom_range(255)));
            4, 5, 6, 7: add_byte(delim_bytes[$urandom_range(7)]);
            8:          add_end();
            default:    add_text(keyword_text[$urandom_range(2)]);
         endcase
      end
   endtask

   // Entered and left just after a rising edge; returns once the word is taken.
   task automatic send_word(input req_word_type w);
      logic stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic run_row(input stim_row_type r);
      rsp_word_type toks [$];
      send_word(r.stim);
      tokenize_byte(r.stim, toks);
      if (r.typed) begin
         toks = {};
         if (r.count > 0) toks.push_back(r.first);
         if (r.count > 1) toks.push_back(r.second);
      end
      foreach (toks[k]) expected_tokens.push_back(toks[k]);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: token word expected none, got %h", $time, rsp_word);
            mismatch_count++;
         end else begin
            next_token = expected_tokens.pop_front();
            check_field("token_kind", 8'(next_token.token_kind), 8'(rsp_word.token_kind));
            check_field("word_byte", next_token.word_byte, rsp_word.word_byte);
            check_field("keyword_code", 8'(next_token.keyword_code),
                        8'(rsp_word.keyword_code));
            check_field("last_of_run", 8'(next_token.last_of_run), 8'(rsp_word.last_of_run));
         end
      end
   end

   initial begin
      int send_mix [3];
      int rsp_mix [3];
      send_mix = '{28, 79, 0};
      rsp_mix  = '{79, 28, 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      stim_rows = '{
         row(8'h00, 1'b1, 1'b1, 2'd1, tok(TK_END, 8'h00, KW_NONE, 1'b1), NO_TOKEN),
         byte_row("G"), byte_row("E"), byte_row("T"),
         row(CH_COLON, 1'b0, 1'b1, 2'd2, tok(TK_WEND, 8'h00, KW_GET, 1'b0),
             tok(TK_COLON, 8'h00, KW_NONE, 1'b1)),
         byte_row("P"), byte_row("O"), byte_row("S"), byte_row("T"),
         row(CH_CR, 1'b0, 1'b1, 2'd2, tok(TK_WEND, 8'h00, KW_POST, 1'b0),
             tok(TK_CRLF, 8'h00, KW_NONE, 1'b1)),
         row(CH_LF, 1'b0, 1'b1, 2'd0, NO_TOKEN, NO_TOKEN),
         row(CH_VT, 1'b0, 1'b1, 2'd1, tok(TK_CRLF, 8'h00, KW_NONE, 1'b1), NO_TOKEN),
         byte_row("H"), byte_row("E"), byte_row("A"), byte_row("D"),
         row(CH_TAB, 1'b0, 1'b1, 2'd2, tok(TK_WEND, 8'h00, KW_HEAD, 1'b0),
             tok(TK_BLANK, 8'h00, KW_NONE, 1'b1)),
         row(CH_QMARK, 1'b0, 1'b1, 2'd1, tok(TK_QMARK, 8'h00, KW_NONE, 1'b1), NO_TOKEN),
         byte_row(8'h00), byte_row(CH_QMARK), byte_row(8'hFF), byte_row(8'h80),
         byte_row("X"), byte_row("T"),
         row(8'hFF, 1'b1, 1'b1, 2'd2, tok(TK_WEND, 8'h00, KW_NONE, 1'b0),
             tok(TK_END, 8'h00, KW_NONE, 1'b1)),
         row(8'h00, 1'b1, 1'b1, 2'd1, tok(TK_END, 8'h00, KW_NONE, 1'b1), NO_TOKEN),
         row(CH_CR, 1'b0, 1'b1, 2'd1, tok(TK_CRLF, 8'h00, KW_NONE, 1'b1), NO_TOKEN),
         row(8'h00, 1'b1, 1'b1, 2'd1, tok(TK_END, 8'h00, KW_NONE, 1'b1), NO_TOKEN),
         row(CH_LF, 1'b0, 1'b1, 2'd1, tok(TK_CRLF, 8'h00, KW_NONE, 1'b1), NO_TOKEN)
      };

      for (int p = 0; p < 3; p++) begin
         send_idle_pct = send_mix[p];
         rsp_stall_pct = rsp_mix[p];
         while (stim_rows.size() < PHASE_WORDS) begin
            if ($urandom_range(9) < 7) add_request();
            else add_noise();
         end
         while (stim_rows.size() != 0) run_row(stim_rows.pop_front());
         // Hold off the sender until every token of this phase is out.
         req_valid <= 1'b0;
         do @(posedge clock); while (expected_tokens.size() != 0);
      end

      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_tokens.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
